### sv/vnorm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_pkg
// Shared types and constants of the 3-vector normalizer.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int DIV_STEPS  = 63;
  localparam int SQRT_STEPS = 32;
  localparam int LANE_LAT   = 1 + DIV_STEPS + SQRT_STEPS;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_EPS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_TOL = 1'b1;

  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [31:0] NEG_ONE_Q16 = -32'sd65536;
  localparam logic [63:0]        ONE_Q32     = 64'h0000_0001_0000_0000;
  localparam logic [31:0]        EPS_RESET   = 32'd512;

  typedef struct packed {
    logic [2:0]       neg;
    logic [2:0][31:0] pass;
    logic             zero;
    logic             renorm;
    logic             oor;
  } side_t;

endpackage

### sv/vnorm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_if
// Handshake channels of the normalizer: vector in, result out, config write.
// ----------------------------------------------------------------------------
interface vnorm_vec_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x;
  logic signed [31:0] y;
  logic signed [31:0] z;
  modport source (output valid, x, y, z, input ready);
  modport sink (input valid, x, y, z, output ready);
endinterface

interface vnorm_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               status;
  logic               out_of_range;
  logic               renormalized;
  modport source (output valid, out_x, out_y, out_z, status, out_of_range, renormalized,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, status, out_of_range, renormalized,
                output ready);
endinterface

interface vnorm_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### sv/vnorm_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnorm_lane
// One component: restoring divide of m2*2^62 by the squared length, one
// quotient bit per stage, then an integer square root, one bit per stage.
// ----------------------------------------------------------------------------
module vnorm_lane (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] m2,
  input  logic [63:0] len2,
  output logic [31:0] root
);
  import vnorm_pkg::*;

  logic [63:0] rem [0:DIV_STEPS];
  logic [62:0] quo [0:DIV_STEPS];
  logic [63:0] dvs [0:DIV_STEPS];
  logic        lsb;
  logic [63:0] num [1:SQRT_STEPS];
  logic [63:0] res [1:SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {1'b0, m2[63:1]};
      quo[0] <= '0;
      dvs[0] <= len2;
      lsb    <= m2[0];
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [64:0] trial;
    logic [64:0] diff;
    assign trial = {rem[k], (k == 0) ? lsb : 1'b0};
    assign diff  = trial - {1'b0, dvs[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        dvs[k+1] <= dvs[k];
        if (trial >= {1'b0, dvs[k]}) begin
          rem[k+1] <= diff[63:0];
          quo[k+1] <= {quo[k][61:0], 1'b1};
        end else begin
          rem[k+1] <= trial[63:0];
          quo[k+1] <= {quo[k][61:0], 1'b0};
        end
      end
    end
  end

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STEPS - 1 - j));
    logic [63:0] num_cur;
    logic [63:0] res_cur;
    logic [63:0] trial;
    if (j == 0) begin : g_first
      assign num_cur = {1'b0, quo[DIV_STEPS]};
      assign res_cur = '0;
    end else begin : g_rest
      assign num_cur = num[j];
      assign res_cur = res[j];
    end
    assign trial = res_cur + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (num_cur >= trial) begin
          num[j+1] <= num_cur - trial;
          res[j+1] <= (res_cur >> 1) + BIT;
        end else begin
          num[j+1] <= num_cur;
          res[j+1] <= res_cur >> 1;
        end
      end
    end
  end

  assign root = res[SQRT_STEPS][31:0];

endmodule

### sv/vec3_normalizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_normalizer_core
// Normalizes a Q16.16 3-vector to Q2.30 with zero-length and range flags.
// ----------------------------------------------------------------------------
// Fully pipelined: one vector is accepted per cycle while the output is not
// stalled. The pipeline is mostly the per-component divider (63 stages, one
// quotient bit each) followed by the square root (32 stages, one root bit
// each). A stall at the output freezes the whole pipeline. Configuration
// writes are taken at any time and apply to vectors that reach the length
// check afterwards.
module vec3_normalizer_core (
  input  logic         clk,
  input  logic         rst,
  vnorm_vec_if.sink    vin,
  vnorm_res_if.source  vout,
  vnorm_cfg_if.sink    cfg
);
  import vnorm_pkg::*;

  logic        en;
  logic [31:0] zero_epsilon;
  logic [31:0] unit_tolerance;

  logic                   v1, v2, v3;
  logic [2:0][31:0]       raw1, raw2, raw3;
  logic [2:0][63:0]       m2_2, m2_3;
  logic                   oor2, oor3;
  logic [63:0]            len3;
  logic [63:0]            len2_next;
  logic [2:0][31:0]       mag1;
  logic                   oor_next;
  side_t                  side_in;
  logic [63:0]            len_dev;
  side_t                  sb  [0:LANE_LAT-1];
  logic [LANE_LAT-1:0]    vld;
  logic [2:0][31:0]       root;
  logic [2:0][31:0]       comp_next;

  assign en        = !vout.valid || vout.ready;
  assign vin.ready = en;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_epsilon   <= EPS_RESET;
      unit_tolerance <= EPS_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ZERO_EPS: zero_epsilon   <= cfg.data;
        CFG_UNIT_TOL: unit_tolerance <= cfg.data;
        default: ;
      endcase
    end
  end

  // magnitudes and range check
  always_comb begin
    oor_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      mag1[i] = raw1[i][31] ? (32'd0 - raw1[i]) : raw1[i];
      if ($signed(raw1[i]) > ONE_Q16 || $signed(raw1[i]) < NEG_ONE_Q16) oor_next = 1'b1;
    end
  end

  assign len2_next = m2_2[0] + m2_2[1] + m2_2[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= vin.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      raw1 <= {vin.z, vin.y, vin.x};
      raw2 <= raw1;
      oor2 <= oor_next;
      for (int i = 0; i < 3; i++) m2_2[i] <= mag1[i] * mag1[i];
      raw3 <= raw2;
      m2_3 <= m2_2;
      oor3 <= oor2;
      len3 <= len2_next;
    end
  end

  assign len_dev = (len3 >= ONE_Q32) ? (len3 - ONE_Q32) : (ONE_Q32 - len3);

  always_comb begin
    side_in.oor    = oor3;
    side_in.zero   = (len3 == 64'd0) || (len3 < {32'd0, zero_epsilon});
    side_in.renorm = len_dev >= {32'd0, unit_tolerance};
    for (int i = 0; i < 3; i++) begin
      side_in.neg[i]  = raw3[i][31];
      side_in.pass[i] = {raw3[i][17:0], 14'd0};
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_lane
    vnorm_lane u_lane (
      .clk  (clk),
      .en   (en),
      .m2   (m2_3[i]),
      .len2 (len3),
      .root (root[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LANE_LAT-2:0], v3};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb[0] <= side_in;
      for (int k = 1; k < LANE_LAT; k++) sb[k] <= sb[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [32:0] rnd;
      logic [31:0] q;
      rnd = {1'b0, root[i]} + 33'd1;
      q   = rnd[32:1];
      if (sb[LANE_LAT-1].zero) begin
        comp_next[i] = '0;
      end else if (sb[LANE_LAT-1].renorm) begin
        comp_next[i] = sb[LANE_LAT-1].neg[i] ? (32'd0 - q) : q;
      end else begin
        comp_next[i] = sb[LANE_LAT-1].pass[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout.valid <= 1'b0;
    end else if (en) begin
      vout.valid <= vld[LANE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vout.out_x        <= comp_next[0];
      vout.out_y        <= comp_next[1];
      vout.out_z        <= comp_next[2];
      vout.status       <= sb[LANE_LAT-1].zero;
      vout.out_of_range <= sb[LANE_LAT-1].oor;
      vout.renormalized <= sb[LANE_LAT-1].renorm && !sb[LANE_LAT-1].zero;
    end
  end

  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    vout.valid && vout.status |-> vout.out_x == 0 && vout.out_y == 0 && vout.out_z == 0)
    else $error("zero-length result carries nonzero components");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    vout.valid |-> !(vout.status && vout.renormalized))
    else $error("error and renormalized both set");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    vout.valid && vout.renormalized |->
      $signed(vout.out_x) <= 32'sh4000_0000 && $signed(vout.out_x) >= -32'sh4000_0000)
    else $error("renormalized component out of unit range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    vin.ready == (!vout.valid || vout.ready))
    else $error("input ready does not follow pipeline advance");

endmodule

### dv/vec3_normalizer_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_normalizer_core_checker
// Watches the vector, result and register channels of the normalizer, computes
// the expected result of every accepted vector from its own copy of the
// registers, and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
module vec3_normalizer_core_checker
  import vnorm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  vnorm_vec_if  vin,
  vnorm_res_if  vout,
  vnorm_cfg_if  cfg,
  output int    fail_count,
  output int    pending,
  output int    checked,
  output int    n_zero,
  output int    n_renorm,
  output int    n_oor
);

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        status;
    logic        oor;
    logic        renorm;
  } norm_res_t;

  norm_res_t   expected_q[$];
  logic [31:0] zero_eps;
  logic [31:0] unit_tol;

  // largest q in [0, 2^30] with (2q-1)^2 * len2 <= mag^2 * 2^62
  function automatic logic [31:0] unit_mag(logic [63:0] mag, logic [63:0] len2);
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [63:0]  lo;
    logic [63:0]  hi;
    logic [63:0]  mid;
    logic [63:0]  t;
    rhs = {64'd0, mag * mag} << 62;
    lo  = 0;
    hi  = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t   = 2 * mid - 1;
      lhs = {64'd0, t * t} * {64'd0, len2};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo[31:0];
  endfunction

  function automatic norm_res_t normalize(logic [31:0] vx, logic [31:0] vy,
                                          logic [31:0] vz);
    norm_res_t          r;
    logic [31:0]        comp [3];
    logic signed [63:0] sv;
    logic [63:0]        mag [3];
    logic [63:0]        len2;
    logic [63:0]        diff;
    logic [31:0]        q;
    comp[0] = vx;
    comp[1] = vy;
    comp[2] = vz;
    len2    = 0;
    r.oor   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      sv     = 64'(signed'(comp[i]));
      mag[i] = sv < 0 ? -sv : sv;
      if (signed'(comp[i]) > ONE_Q16 || signed'(comp[i]) < NEG_ONE_Q16) r.oor = 1'b1;
      len2 += mag[i] * mag[i];
    end
    r.renorm = 1'b0;
    r.status = 1'b0;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    if (len2 == 0 || len2 < {32'd0, zero_eps}) begin
      r.status = 1'b1;
      return r;
    end
    diff = len2 >= ONE_Q32 ? len2 - ONE_Q32 : ONE_Q32 - len2;
    if (diff >= {32'd0, unit_tol}) begin
      r.renorm = 1'b1;
      for (int i = 0; i < 3; i++) begin
        q = unit_mag(mag[i], len2);
        if (comp[i][31]) q = -q;
        comp[i] = q;
      end
    end else begin
      for (int i = 0; i < 3; i++) comp[i] = comp[i] << 14;
    end
    r.x = comp[0];
    r.y = comp[1];
    r.z = comp[2];
    return r;
  endfunction

  always @(posedge clk) begin
    norm_res_t e;
    if (rst) begin
      zero_eps   <= EPS_RESET;
      unit_tol   <= EPS_RESET;
      fail_count <= 0;
      checked    <= 0;
      n_zero     <= 0;
      n_renorm   <= 0;
      n_oor      <= 0;
      expected_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_ZERO_EPS) zero_eps <= cfg.data;
        else if (cfg.index == CFG_UNIT_TOL) unit_tol <= cfg.data;
      end
      if (vin.valid && vin.ready) begin
        e = normalize(vin.x, vin.y, vin.z);
        expected_q.push_back(e);
        n_zero   <= n_zero + e.status;
        n_renorm <= n_renorm + e.renorm;
        n_oor    <= n_oor + e.oor;
      end
      if (vout.valid && vout.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          checked <= checked + 1;
          if (vout.out_x !== e.x || vout.out_y !== e.y || vout.out_z !== e.z ||
              vout.status !== e.status || vout.out_of_range !== e.oor ||
              vout.renormalized !== e.renorm) begin
            fail_count <= fail_count + 1;
            if (vout.out_x !== e.x)
              $error("out_x expected %h actual %h", e.x, vout.out_x);
            if (vout.out_y !== e.y)
              $error("out_y expected %h actual %h", e.y, vout.out_y);
            if (vout.out_z !== e.z)
              $error("out_z expected %h actual %h", e.z, vout.out_z);
            if (vout.status !== e.status)
              $error("status expected %b actual %b", e.status, vout.status);
            if (vout.out_of_range !== e.oor)
              $error("out_of_range expected %b actual %b", e.oor, vout.out_of_range);
            if (vout.renormalized !== e.renorm)
              $error("renormalized expected %b actual %b", e.renorm, vout.renormalized);
          end
        end
      end
    end
  end

  assign pending = expected_q.size();

endmodule

### dv/vec3_normalizer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vec3_normalizer_core_test
// Drives the normalizer with directed and random vectors under several
// register settings, with bursty input and a stalling output, including one
// long output hold-off. The checker beside the block compares every result.
// ----------------------------------------------------------------------------
module vec3_normalizer_core_test;
  import vnorm_pkg::*;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   checked;
  int   n_zero;
  int   n_renorm;
  int   n_oor;
  int   sent;
  int   burst_left;
  bit   hold_done;

  vnorm_vec_if vin ();
  vnorm_res_if vout ();
  vnorm_cfg_if cfg ();

  vec3_normalizer_core u_top (
    .clk  (clk),
    .rst  (rst),
    .vin  (vin),
    .vout (vout),
    .cfg  (cfg)
  );

  vec3_normalizer_core_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .vin        (vin),
    .vout       (vout),
    .cfg        (cfg),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .n_zero     (n_zero),
    .n_renorm   (n_renorm),
    .n_oor      (n_oor)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // output stall pattern, with one long hold-off while input keeps coming
  initial begin
    int mode;
    int stretch;
    vout.ready = 1'b0;
    hold_done  = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      if (!hold_done && sent >= 150) begin
        hold_done = 1'b1;
        vout.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      mode    = $urandom_range(0, 2);
      stretch = $urandom_range(5, 60);
      repeat (stretch) begin
        case (mode)
          0: vout.ready <= 1'b1;
          1: vout.ready <= $urandom_range(0, 1);
          default: vout.ready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [31:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    if (vin.valid) begin
      vin.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (LANE_LAT + 10) @(posedge clk);
  endtask

  // bursts of random length separated by random gaps
  task automatic send_vec(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0 && vin.valid) begin
        vin.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    vin.valid <= 1'b1;
    vin.x     <= vx;
    vin.y     <= vy;
    vin.z     <= vz;
    do @(posedge clk); while (!vin.ready);
    sent++;
  endtask

  function automatic logic [31:0] rand_signed(int span);
    int v;
    v = $urandom_range(0, 2 * span) - span;
    return v;
  endfunction

  task automatic send_random();
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] vz;
    real         rem;
    case ($urandom_range(0, 5))
      0: begin
        vx = $urandom;
        vy = $urandom;
        vz = $urandom;
      end
      1: begin
        vx = rand_signed(65536 + 4);
        vy = rand_signed(65536 + 4);
        vz = rand_signed(65536 + 4);
      end
      2, 3: begin
        vx  = rand_signed(40000);
        vy  = rand_signed(40000);
        rem = 4294967296.0 - real'(signed'(vx)) ** 2 - real'(signed'(vy)) ** 2;
        vz  = $rtoi($sqrt(rem) + 0.5) + $urandom_range(0, 6) - 3;
        if ($urandom_range(0, 1)) vz = -vz;
      end
      4: begin
        vx = rand_signed(64);
        vy = rand_signed(64);
        vz = rand_signed(64);
      end
      default: begin
        vx = signed'($urandom) >>> $urandom_range(0, 31);
        vy = signed'($urandom) >>> $urandom_range(0, 31);
        vz = signed'($urandom) >>> $urandom_range(0, 31);
      end
    endcase
    send_vec(vx, vy, vz);
  endtask

  initial begin
    rst        = 1'b1;
    sent       = 0;
    burst_left = 0;
    vin.valid  = 1'b0;
    vin.x      = '0;
    vin.y      = '0;
    vin.z      = '0;
    cfg.valid  = 1'b0;
    cfg.index  = CFG_ZERO_EPS;
    cfg.data   = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset register values
    send_vec(32'h0, 32'h0, 32'h0);
    send_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vec(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vec(32'h7fff_ffff, 32'h8000_0000, 32'h0);
    send_vec(ONE_Q16, 32'h0, 32'h0);
    send_vec(32'h0, NEG_ONE_Q16, 32'h0);
    send_vec(32'h0, 32'h0, ONE_Q16 + 1);
    send_vec(NEG_ONE_Q16 - 1, 32'h0, 32'h0);
    send_vec(32'd16, 32'd16, 32'h0);
    send_vec(32'd16, 32'd15, 32'h0);
    send_vec(-32'sd1, 32'd0, 32'd1);
    send_vec(32'd37837, 32'd37837, 32'd37837);
    send_vec(32'd37838, -32'sd37838, 32'd37838);
    send_vec(32'd46341, 32'd46341, 32'h0);
    send_vec(ONE_Q16, ONE_Q16, ONE_Q16);
    send_vec(32'd1, 32'h0, 32'h0);
    send_vec(32'h0, 32'h0, -32'sd2147483647);
    repeat (100) send_random();
    drain();

    // zero thresholds: only the exact zero vector is an error
    write_reg(CFG_ZERO_EPS, 32'h0);
    write_reg(CFG_UNIT_TOL, 32'h0);
    send_vec(32'h0, 32'h0, 32'h0);
    send_vec(ONE_Q16, 32'h0, 32'h0);
    send_vec(32'h0, 32'h1, 32'h0);
    repeat (110) send_random();
    drain();

    // maximum thresholds
    write_reg(CFG_ZERO_EPS, 32'hffff_ffff);
    write_reg(CFG_UNIT_TOL, 32'hffff_ffff);
    send_vec(ONE_Q16, 32'h0, 32'h0);
    send_vec(32'd65535, 32'd100, 32'h0);
    send_vec(32'd92682, 32'd0, 32'd0);
    repeat (110) send_random();
    drain();

    // random moderate thresholds, wide unit tolerance
    write_reg(CFG_ZERO_EPS, $urandom_range(0, 1 << 20));
    write_reg(CFG_UNIT_TOL, $urandom_range(1 << 20, 1 << 30));
    repeat (110) send_random();
    drain();

    $display("vectors sent %0d, results checked %0d", sent, checked);
    $display("zero-length %0d, renormalized %0d, out of range %0d",
             n_zero, n_renorm, n_oor);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
